FILE: sv/fbf_pkg.sv
// ----------------------------------------------------------------------------
// fbf_pkg
// shared types and constants of the page framebuffer flusher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbf_pkg;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       color;
    logic [2:0] page_select;
    logic       transfer_failed;
    logic       bus_busy;
  } fbf_in_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [6:0]  tx_address;
    logic        ready_res;
    logic [2:0]  sequencer_state;
    logic [15:0] error_count;
  } fbf_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic apply;
    logic pix_rd;
    logic pix_wr;
    logic clr_step;
    logic seq_run;
    logic byte_rd;
    logic byte_push;
  } fbf_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pix_hit;
    logic is_fill;
    logic clr_last;
    logic xfer_start;
    logic byte_last;
    logic out_free;
  } fbf_stat_t;

  localparam logic [2:0] OP_PIXEL      = 3'd0;
  localparam logic [2:0] OP_FILL       = 3'd1;
  localparam logic [2:0] OP_FLUSH_ALL  = 3'd2;
  localparam logic [2:0] OP_FLUSH_PAGE = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;
  localparam logic [2:0] OP_DONE       = 3'd5;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_INIT_WAIT = 3'd1;
  localparam logic [2:0] MODE_INIT_CMD  = 3'd2;
  localparam logic [2:0] MODE_PAGE_CMD  = 3'd3;
  localparam logic [2:0] MODE_PAGE_DATA = 3'd4;
  localparam logic [2:0] MODE_ERROR     = 3'd5;

  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_PAGE = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_POWER_ON_DELAY = 2'd1;
  localparam logic [1:0] REG_RETRY_DELAY    = 2'd2;

  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] PAGE_ADDR_CMD = 8'hB0;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

  localparam logic [4:0] INIT_LEN   = 5'd23;
  localparam int         XFER_MAX   = 32;

  function automatic logic [7:0] init_cmd(input logic [4:0] pos);
    logic [7:0] v;
    case (pos)
      5'd0:    v = 8'hAE;
      5'd1:    v = 8'hD5;
      5'd2:    v = 8'h80;
      5'd3:    v = 8'hA8;
      5'd4:    v = 8'h3F;
      5'd5:    v = 8'hD3;
      5'd6:    v = 8'h00;
      5'd7:    v = 8'h40;
      5'd8:    v = 8'hA1;
      5'd9:    v = 8'hC8;
      5'd10:   v = 8'hDA;
      5'd11:   v = 8'h12;
      5'd12:   v = 8'h81;
      5'd13:   v = 8'hCF;
      5'd14:   v = 8'hD9;
      5'd15:   v = 8'hF1;
      5'd16:   v = 8'hDB;
      5'd17:   v = 8'h30;
      5'd18:   v = 8'hA4;
      5'd19:   v = 8'hA6;
      5'd20:   v = 8'h8D;
      5'd21:   v = 8'h14;
      5'd22:   v = 8'hAF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/fbf_ctrl.sv
// ----------------------------------------------------------------------------
// fbf_ctrl
// cycle controller: sweeps, pixel read-modify-write, sequencer run, byte emit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fbf_pkg::fbf_stat_t stat_i,
  output fbf_pkg::fbf_cmd_t  cmd_o
);
  import fbf_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVENT = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;
  localparam logic [2:0] S_SEQ   = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVENT;
        end
      end
      S_EVENT: begin
        cmd_o.apply = 1'b1;
        if (stat_i.is_fill) begin
          state_d = S_FILL;
        end else if (stat_i.pix_hit) begin
          cmd_o.pix_rd = 1'b1;
          state_d      = S_RMW;
        end else begin
          state_d = S_SEQ;
        end
      end
      S_FILL: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_SEQ;
      end
      S_RMW: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = S_SEQ;
      end
      S_SEQ: begin
        cmd_o.seq_run = 1'b1;
        state_d = stat_i.xfer_start ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.byte_push = 1'b1;
          state_d = stat_i.byte_last ? S_IDLE : S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/fbf_datapath.sv
// ----------------------------------------------------------------------------
// fbf_datapath
// frame memory, configuration, sequencer state and the output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_datapath #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8,
  parameter int CHUNK_BYTES   = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbf_pkg::fbf_in_t   in_data_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbf_pkg::fbf_out_t  out_data_o,
  input  fbf_pkg::fbf_cmd_t  cmd_i,
  output fbf_pkg::fbf_stat_t stat_o
);
  import fbf_pkg::*;

  localparam int DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = (CHUNK_BYTES > XFER_MAX - 1) ? XFER_MAX - 1 : CHUNK_BYTES;
  localparam logic [PAGE_COUNT-1:0] ALL_PAGES = {PAGE_COUNT{1'b1}};

  // frame memory
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  fbf_in_t item_q;

  logic [6:0]  dev_addr_q;
  logic [15:0] retry_q;

  logic [AW-1:0]         clr_cnt_q;
  logic                  fill_val_q, fill_val_d;
  logic [PAGE_COUNT-1:0] dirty_q, dirty_d;
  logic [2:0]            mode_q, mode_d;
  logic                  ready_q, ready_d;
  logic [4:0]            pos_q, pos_d;
  logic [2:0]            fpage_q, fpage_d;
  logic [7:0]            fcol_q, fcol_d;
  logic [15:0]           wait_q, wait_d;
  logic [15:0]           fail_q, fail_d;

  logic [1:0]    xkind_q, xkind_d;
  logic [5:0]    xlen_q, xlen_d;
  logic [4:0]    xidx_q;
  logic [AW-1:0] xbase_q, xbase_d;
  logic          start;

  logic          out_valid_q;
  fbf_out_t      out_q;

  // pixel decode
  logic          pix_hit;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  logic [2:0]    pix_page;

  assign pix_page = item_q.pixel_y[5:3];
  assign pix_hit  = ({1'b0, item_q.pixel_x} < 8'(DISPLAY_WIDTH)) &&
                    ({1'b0, item_q.pixel_y} < 7'(PAGE_COUNT * 8));
  assign pix_addr = AW'(int'(pix_page) * DISPLAY_WIDTH + int'(item_q.pixel_x));
  assign pix_mask = 8'(1) << item_q.pixel_y[2:0];

  // chunk sizing
  logic [8:0]    remain;
  logic [5:0]    chunk;
  logic [AW-1:0] data_base;
  logic [AW:0]   byte_addr;

  assign remain    = 9'(DISPLAY_WIDTH) - {1'b0, fcol_q};
  assign chunk     = (remain < 9'(CB)) ? remain[5:0] : 6'(CB);
  assign data_base = AW'(int'(fpage_q) * DISPLAY_WIDTH + int'(fcol_q));
  assign byte_addr = {1'b0, xbase_q} + (AW+1)'(xidx_q) - (AW+1)'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = {8{fill_val_q}};
    mem_raddr = pix_addr;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.pix_wr) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr;
      mem_wdata = item_q.color ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
    end
    if (cmd_i.byte_rd) mem_raddr = byte_addr[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.pix_rd || cmd_i.byte_rd) rdata_q <= mem[mem_raddr];
    if (cmd_i.load) item_q <= in_data_i;
  end

  // event application and sequencer step
  always_comb begin
    dirty_d    = dirty_q;
    mode_d     = mode_q;
    ready_d    = ready_q;
    pos_d      = pos_q;
    fpage_d    = fpage_q;
    fcol_d     = fcol_q;
    wait_d     = wait_q;
    fail_d     = fail_q;
    fill_val_d = fill_val_q;
    xkind_d    = xkind_q;
    xlen_d     = xlen_q;
    xbase_d    = xbase_q;
    start      = 1'b0;

    if (cfg_we_i && cfg_idx_i == REG_POWER_ON_DELAY && mode_q == MODE_INIT_WAIT) begin
      wait_d = cfg_data_i;
    end

    if (cmd_i.apply) begin
      case (item_q.op)
        OP_PIXEL: begin
          for (int p = 0; p < PAGE_COUNT; p++) begin
            if (pix_hit && pix_page == 3'(p)) dirty_d[p] = 1'b1;
          end
        end
        OP_FILL: begin
          fill_val_d = item_q.color;
          dirty_d    = ALL_PAGES;
        end
        OP_FLUSH_ALL: dirty_d = ALL_PAGES;
        OP_FLUSH_PAGE: begin
          for (int p = 0; p < PAGE_COUNT; p++) begin
            if (item_q.page_select == 3'(p)) dirty_d[p] = 1'b1;
          end
        end
        OP_TICK: begin
          if (wait_q != 16'd0) wait_d = wait_q - 16'd1;
        end
        default: ;
      endcase
    end

    if (cmd_i.seq_run) begin
      case (mode_q)
        MODE_INIT_WAIT, MODE_INIT_CMD: begin
          if ((mode_q == MODE_INIT_WAIT && wait_q == 16'd0 && !item_q.bus_busy) ||
              (mode_q == MODE_INIT_CMD && item_q.op == OP_DONE &&
               !item_q.transfer_failed)) begin
            if (mode_q == MODE_INIT_CMD) pos_d = pos_q + 5'd1;
            if (pos_d >= INIT_LEN) begin
              ready_d = 1'b1;
              mode_d  = MODE_IDLE;
              dirty_d = ALL_PAGES;
            end else begin
              start   = 1'b1;
              xkind_d = KIND_INIT;
              xlen_d  = 6'd2;
              mode_d  = MODE_INIT_CMD;
            end
          end else if (mode_q == MODE_INIT_CMD && item_q.op == OP_DONE) begin
            if (fail_q != 16'hFFFF) fail_d = fail_q + 16'd1;
            mode_d = MODE_ERROR;
          end
        end
        MODE_PAGE_CMD, MODE_PAGE_DATA: begin
          if (item_q.op == OP_DONE) begin
            if (item_q.transfer_failed) begin
              if (fail_q != 16'hFFFF) fail_d = fail_q + 16'd1;
              for (int p = 0; p < PAGE_COUNT; p++) begin
                if (fpage_q == 3'(p)) dirty_d[p] = 1'b1;
              end
              mode_d = MODE_ERROR;
            end else if ({1'b0, fcol_q} >= 9'(DISPLAY_WIDTH) ||
                         {1'b0, fpage_q} >= 4'(PAGE_COUNT)) begin
              mode_d = MODE_IDLE;
            end else begin
              start   = 1'b1;
              xkind_d = KIND_DATA;
              xlen_d  = chunk + 6'd1;
              xbase_d = data_base;
              fcol_d  = fcol_q + {2'b0, chunk};
              mode_d  = MODE_PAGE_DATA;
            end
          end
        end
        MODE_ERROR: begin
          if (!ready_q) begin
            pos_d  = 5'd0;
            wait_d = retry_q;
            mode_d = MODE_INIT_WAIT;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          if (ready_q && !item_q.bus_busy) begin
            // lowest dirty page wins
            for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
              if (dirty_q[p]) begin
                start   = 1'b1;
                fpage_d = 3'(p);
              end
            end
            if (start) begin
              xkind_d = KIND_PAGE;
              xlen_d  = 6'd4;
              fcol_d  = 8'd0;
              mode_d  = MODE_PAGE_CMD;
              for (int p = 0; p < PAGE_COUNT; p++) begin
                if (fpage_d == 3'(p)) dirty_d[p] = 1'b0;
              end
            end
          end
        end
      endcase
    end

    if (cmd_i.pix_wr) begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
        if (pix_page == 3'(p)) dirty_d[p] = 1'b1;
      end
    end
  end

  // byte of the current transfer
  logic [7:0] cur_byte;
  always_comb begin
    cur_byte = CTRL_CMD;
    case (xkind_q)
      KIND_INIT: cur_byte = (xidx_q == 5'd0) ? CTRL_CMD : init_cmd(pos_q);
      KIND_PAGE: begin
        case (xidx_q[1:0])
          2'd1:    cur_byte = PAGE_ADDR_CMD | {5'b0, fpage_q};
          2'd3:    cur_byte = COL_HIGH_CMD;
          default: cur_byte = CTRL_CMD;
        endcase
      end
      KIND_DATA: cur_byte = (xidx_q == 5'd0) ? CTRL_DATA : rdata_q;
      default:   cur_byte = CTRL_CMD;
    endcase
  end

  logic byte_last;
  assign byte_last = ({1'b0, xidx_q} == xlen_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 7'd60;
      retry_q     <= 16'd100;
      clr_cnt_q   <= '0;
      fill_val_q  <= 1'b0;
      dirty_q     <= '0;
      mode_q      <= MODE_INIT_WAIT;
      ready_q     <= 1'b0;
      pos_q       <= 5'd0;
      fpage_q     <= 3'd0;
      fcol_q      <= 8'd0;
      wait_q      <= 16'd50;
      fail_q      <= 16'd0;
      xkind_q     <= KIND_INIT;
      xlen_q      <= 6'd0;
      xidx_q      <= 5'd0;
      xbase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the power-on delay only reloads the wait counter
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[6:0];
          REG_RETRY_DELAY:    retry_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= (clr_cnt_q == AW'(DEPTH - 1)) ? '0 : clr_cnt_q + AW'(1);
      end
      fill_val_q <= fill_val_d;
      dirty_q    <= dirty_d;
      mode_q     <= mode_d;
      ready_q    <= ready_d;
      pos_q      <= pos_d;
      fpage_q    <= fpage_d;
      fcol_q     <= fcol_d;
      wait_q     <= wait_d;
      fail_q     <= fail_d;
      xkind_q    <= xkind_d;
      xlen_q     <= xlen_d;
      xbase_q    <= xbase_d;
      if (cmd_i.seq_run) begin
        xidx_q <= 5'd0;
      end else if (cmd_i.byte_push) begin
        xidx_q <= xidx_q + 5'd1;
      end
      if (cmd_i.byte_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_push) begin
      out_q.tx_byte         <= cur_byte;
      out_q.tx_last         <= byte_last;
      out_q.tx_address      <= dev_addr_q;
      out_q.ready_res       <= ready_q;
      out_q.sequencer_state <= mode_q;
      out_q.error_count     <= fail_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.pix_hit    = pix_hit && (item_q.op == OP_PIXEL);
  assign stat_o.is_fill    = (item_q.op == OP_FILL);
  assign stat_o.clr_last   = (clr_cnt_q == AW'(DEPTH - 1));
  assign stat_o.xfer_start = start;
  assign stat_o.byte_last  = byte_last;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

FILE: sv/oled_framebuffer_page_flusher.sv
// Page framebuffer with an init and flush sequencer. After reset the block
// sweeps all DISPLAY_WIDTH*PAGE_COUNT bytes (1024 by default) to clear the frame
// memory and takes no word in that time; a fill repeats that sweep. A pixel
// write does a read-modify-write of one memory byte, and each emitted byte
// takes a memory read, then the output register, and can wait on an output stall.
// ----------------------------------------------------------------------------
// oled_framebuffer_page_flusher
// top level: controller plus datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oled_framebuffer_page_flusher #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8,
  parameter int CHUNK_BYTES   = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fbf_pkg::fbf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fbf_pkg::fbf_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import fbf_pkg::*;

  fbf_cmd_t  cmd;
  fbf_stat_t stat;

  fbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbf_datapath #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .PAGE_COUNT    (PAGE_COUNT),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: tb/sv/oled_framebuffer_page_flusher_tb.sv
// ----------------------------------------------------------------------------
// oled_framebuffer_page_flusher_tb
// drives events into the framebuffer flusher, predicts every transmitted
// byte with a behavioral model of the sequencer and checks the output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class flush_scoreboard;
  logic [6:0]  dev_addr;
  logic [15:0] pwr_delay;
  logic [15:0] rty_delay;
  logic [7:0]  frame [1024];
  logic [7:0]  dirty;
  logic [2:0]  mode;
  logic        ready;
  int          init_pos;
  int          cur_page;
  int          cur_col;
  logic [15:0] wait_left;
  logic [15:0] fails;
  fbf_pkg::fbf_out_t pending[$];
  logic [7:0]  xbuf[$];
  int          errors;

  function void clear();
    dev_addr = 7'd60;
    pwr_delay = 16'd50;
    rty_delay = 16'd100;
    foreach (frame[i]) frame[i] = 8'h00;
    dirty = 8'h00;
    mode = fbf_pkg::MODE_INIT_WAIT;
    ready = 1'b0;
    init_pos = 0;
    cur_page = 0;
    cur_col = 0;
    wait_left = pwr_delay;
    fails = 16'd0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == fbf_pkg::REG_DEVICE_ADDRESS) begin
      dev_addr = val[6:0];
    end else if (idx == fbf_pkg::REG_POWER_ON_DELAY) begin
      pwr_delay = val;
      if (mode == fbf_pkg::MODE_INIT_WAIT) wait_left = val;
    end else if (idx == fbf_pkg::REG_RETRY_DELAY) begin
      rty_delay = val;
    end
  endfunction

  function void next_init();
    logic [7:0] cmds [23];
    cmds = '{8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
             8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
             8'hDB, 8'h30, 8'hA4, 8'hA6, 8'h8D, 8'h14, 8'hAF};
    if (init_pos >= 23) begin
      ready = 1'b1;
      mode = fbf_pkg::MODE_IDLE;
      dirty = 8'hFF;
      return;
    end
    xbuf.push_back(fbf_pkg::CTRL_CMD);
    xbuf.push_back(cmds[init_pos]);
    mode = fbf_pkg::MODE_INIT_CMD;
  endfunction

  function void next_chunk();
    int n;
    if (cur_col >= 128) begin
      mode = fbf_pkg::MODE_IDLE;
      return;
    end
    n = 128 - cur_col;
    if (n > 31) n = 31;
    xbuf.push_back(fbf_pkg::CTRL_DATA);
    for (int i = 0; i < n; i++) xbuf.push_back(frame[cur_page * 128 + cur_col + i]);
    cur_col += n;
    mode = fbf_pkg::MODE_PAGE_DATA;
  endfunction

  function void sequence_step(fbf_pkg::fbf_in_t w);
    case (mode)
      fbf_pkg::MODE_INIT_WAIT: begin
        if (wait_left == 0 && !w.bus_busy) next_init();
      end
      fbf_pkg::MODE_INIT_CMD, fbf_pkg::MODE_PAGE_CMD, fbf_pkg::MODE_PAGE_DATA: begin
        if (w.op != fbf_pkg::OP_DONE) return;
        if (w.transfer_failed) begin
          if (fails != 16'hFFFF) fails++;
          if (mode != fbf_pkg::MODE_INIT_CMD) dirty[cur_page] = 1'b1;
          mode = fbf_pkg::MODE_ERROR;
        end else if (mode == fbf_pkg::MODE_INIT_CMD) begin
          init_pos++;
          next_init();
        end else begin
          next_chunk();
        end
      end
      fbf_pkg::MODE_ERROR: begin
        if (!ready) begin
          init_pos = 0;
          wait_left = rty_delay;
          mode = fbf_pkg::MODE_INIT_WAIT;
        end else begin
          mode = fbf_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode = fbf_pkg::MODE_IDLE;
        if (!ready || w.bus_busy) return;
        for (int p = 0; p < 8; p++) begin
          if (dirty[p]) begin
            xbuf.push_back(fbf_pkg::CTRL_CMD);
            xbuf.push_back(fbf_pkg::PAGE_ADDR_CMD | 8'(p));
            xbuf.push_back(fbf_pkg::CTRL_CMD);
            xbuf.push_back(fbf_pkg::COL_HIGH_CMD);
            cur_page = p;
            cur_col = 0;
            dirty[p] = 1'b0;
            mode = fbf_pkg::MODE_PAGE_CMD;
            return;
          end
        end
      end
    endcase
  endfunction

  // notes one accepted input word and queues the bytes it sends
  function void note_input(fbf_pkg::fbf_in_t w);
    fbf_pkg::fbf_out_t r;
    int idx;
    xbuf.delete();
    case (w.op)
      fbf_pkg::OP_PIXEL: begin
        idx = int'(w.pixel_y >> 3) * 128 + int'(w.pixel_x);
        frame[idx][w.pixel_y[2:0]] = w.color;
        dirty[w.pixel_y >> 3] = 1'b1;
      end
      fbf_pkg::OP_FILL: begin
        foreach (frame[i]) frame[i] = {8{w.color}};
        dirty = 8'hFF;
      end
      fbf_pkg::OP_FLUSH_ALL: dirty = 8'hFF;
      fbf_pkg::OP_FLUSH_PAGE: dirty[w.page_select] = 1'b1;
      fbf_pkg::OP_TICK: if (wait_left != 0) wait_left--;
      default: ;
    endcase
    sequence_step(w);
    foreach (xbuf[i]) begin
      r.tx_byte = xbuf[i];
      r.tx_last = (i == xbuf.size() - 1);
      r.tx_address = dev_addr;
      r.ready_res = ready;
      r.sequencer_state = mode;
      r.error_count = fails;
      pending.push_back(r);
    end
  endfunction

  function void check_result(fbf_pkg::fbf_out_t got);
    fbf_pkg::fbf_out_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.tx_byte !== e.tx_byte)
      $display("%0t: tx_byte expected %h actual %h", $time, e.tx_byte, got.tx_byte);
    if (got.tx_last !== e.tx_last)
      $display("%0t: tx_last expected %b actual %b", $time, e.tx_last, got.tx_last);
    if (got.tx_address !== e.tx_address)
      $display("%0t: tx_address expected %h actual %h", $time, e.tx_address,
               got.tx_address);
    if (got.ready_res !== e.ready_res)
      $display("%0t: ready_res expected %b actual %b", $time, e.ready_res, got.ready_res);
    if (got.sequencer_state !== e.sequencer_state)
      $display("%0t: sequencer_state expected %0d actual %0d", $time,
               e.sequencer_state, got.sequencer_state);
    if (got.error_count !== e.error_count)
      $display("%0t: error_count expected %0d actual %0d", $time, e.error_count,
               got.error_count);
    if (got !== e) errors++;
  endfunction
endclass

module oled_framebuffer_page_flusher_tb;
  import fbf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  fbf_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  fbf_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  flush_scoreboard sb;
  int  cycles = 0;
  bit  quiet_phase = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_off = 0;

  oled_framebuffer_page_flusher DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= quiet_phase ? 1'b0 : ($urandom_range(99) < 10);
    end
  end

  task automatic send(fbf_in_t w);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 10) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    in_valid_i <= 1'b0;
    // the block stalls after a word anyway
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic fbf_in_t mk(logic [2:0] op);
    fbf_in_t w;
    w.op = op;
    w.pixel_x = 7'($urandom_range(127));
    w.pixel_y = 6'($urandom_range(63));
    w.color = 1'($urandom_range(1));
    w.page_select = 3'($urandom_range(7));
    w.bus_busy = ($urandom_range(99) < 15);
    w.transfer_failed = ($urandom_range(99) < 8);
    return w;
  endfunction

  // a given number of words, each a transfer-done word or a tick at random
  task automatic drive_flush(int dones);
    fbf_in_t w;
    for (int i = 0; i < dones; i++) begin
      w = mk($urandom_range(99) < 80 ? OP_DONE : OP_TICK);
      send(w);
    end
  endtask

  initial begin
    fbf_in_t w;
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short power-on delay, extremes, every op
    cfg(REG_POWER_ON_DELAY, 16'd2);
    cfg(REG_DEVICE_ADDRESS, 16'd127);
    cfg(REG_RETRY_DELAY, 16'd0);
    w = '0; w.op = OP_PIXEL; w.pixel_x = 7'd127; w.pixel_y = 6'd63; w.color = 1'b1;
    send(w);
    w.pixel_x = 7'd0; w.pixel_y = 6'd0; send(w);
    w.color = 1'b0; send(w);
    w = '0; w.op = OP_DONE; send(w);
    w = '0; w.op = OP_TICK; w.bus_busy = 1'b1; send(w);
    send(w);
    send(w);
    w.bus_busy = 1'b0; send(w);
    w = '0; w.op = OP_DONE; w.transfer_failed = 1'b1; send(w);
    w = '0; w.op = 3'd6; send(w);
    w.op = 3'd7; send(w);
    w = '0; w.op = OP_DONE; send(w);
    for (int i = 0; i < 24; i++) begin
      w = '0; w.op = OP_DONE; send(w);
    end
    w = '0; w.op = OP_FILL; w.color = 1'b1; send(w);
    w = '0; w.op = OP_FLUSH_PAGE; w.page_select = 3'd7; send(w);
    w = '0; w.op = OP_FLUSH_ALL; send(w);
    for (int i = 0; i < 6; i++) begin
      w = '0; w.op = OP_DONE; w.transfer_failed = (i == 3); send(w);
    end
    settle();

    cfg(REG_DEVICE_ADDRESS, 16'd0);
    cfg(REG_RETRY_DELAY, 16'd65535);
    cfg(REG_POWER_ON_DELAY, 16'd65535);

    // long output hold-off while words keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      w = mk(OP_DONE); w.transfer_failed = 1'b0; send(w);
    end
    settle();

    cfg(REG_DEVICE_ADDRESS, 16'd60);
    cfg(REG_RETRY_DELAY, 16'd3);
    for (int k = 0; k < 120; k++) begin
      if (k == 40) quiet_phase = 1'b1;
      if (k == 70) quiet_phase = 1'b0;
      case ($urandom_range(9))
        0, 1, 2: send(mk(OP_PIXEL));
        3: send(mk(OP_FLUSH_PAGE));
        4: send(mk($urandom_range(3) == 0 ? OP_FILL : OP_FLUSH_ALL));
        5: send(mk(3'($urandom_range(7))));
        default: drive_flush($urandom_range(1, 6));
      endcase
    end
    for (int i = 0; i < 60; i++) begin
      w = mk(OP_DONE); w.transfer_failed = 1'b0; w.bus_busy = 1'b0; send(w);
    end
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
